### hdl/quoted_printable_encoder_unit_defines.svh
// Assertion macros shared by the quoted-printable encoder checker.
`ifndef QUOTED_PRINTABLE_ENCODER_UNIT_DEFINES_SVH
`define QUOTED_PRINTABLE_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define QPE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qpe assertion failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define QPE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qpe assertion failed");

`endif

### hdl/qpe_pkg.sv
// Shared types, constants and helper functions of the quoted-printable encoder.
`timescale 1ns / 1ps
`default_nettype none
package qpe_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned NSLOT = 9;

	localparam logic [7:0] COL_RESET = 8'd73;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_EQ = 8'd61;
	localparam logic [7:0] CH_TILDE = 8'd126;
	localparam logic [7:0] CH_TWO = 8'd50;
	localparam logic [7:0] CH_ZERO = 8'd48;

	typedef enum logic [1:0] {
		HELD_NONE,
		HELD_SPACE,
		HELD_EQ20
	} held_kind_t;

	typedef enum logic [1:0] {
		MAIN_NONE,
		MAIN_LIT,
		MAIN_ESC
	} main_kind_t;

	// One byte's worth of output work, as handed from front to back.
	typedef struct packed {
		held_kind_t held;
		logic brk;
		main_kind_t main;
		logic [7:0] data;
		logic last;
	} job_t;

	function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [1:0] k);
		logic [8:0] s;
		s = {1'b0, a} + {7'b0, k};
		return s[8] ? 8'hFF : s[7:0];
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] w;
		w = {4'b0, v};
		return (v < 4'd10) ? (CH_ZERO + w) : (8'd55 + w);
	endfunction

endpackage
`default_nettype wire

### hdl/qpe_front.sv
// Front end: accepts message bytes, tracks the column, classifies each byte into a job.
`timescale 1ns / 1ps
`default_nettype none
module qpe_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wen,
	input wire logic [7:0] cfg_wdata,
	input wire logic acc,
	input wire logic [7:0] in_byte,
	input wire logic msg_last,
	output qpe_pkg::job_t job,
	output logic job_push
);
	import qpe_pkg::*;

	logic [7:0] col_limit_q;
	logic [7:0] col_q;
	logic held_q;

	logic line_end, escape, is_space;
	logic [7:0] col_a, col_b, col_n;
	logic held_n;

	always_comb begin
		line_end = (in_byte == CH_LF) || (in_byte == CH_CR);
		escape = (in_byte < CH_SPACE) || (in_byte == CH_EQ) || (in_byte > CH_TILDE);
		is_space = (in_byte == CH_SPACE);

		job.data = in_byte;
		job.last = msg_last;
		job.held = HELD_NONE;
		col_a = col_q;
		if (held_q) begin
			job.held = line_end ? HELD_EQ20 : HELD_SPACE;
			col_a = sat_add(col_q, line_end ? 2'd3 : 2'd1);
		end

		job.brk = !line_end && (col_a >= col_limit_q);
		col_b = job.brk ? 8'd0 : col_a;

		held_n = 1'b0;
		if (line_end) begin
			job.main = MAIN_LIT;
			col_n = 8'd0;
		end else if (escape) begin
			job.main = MAIN_ESC;
			col_n = sat_add(col_b, 2'd3);
		end else if (is_space && !msg_last) begin
			job.main = MAIN_NONE;
			col_n = col_b;
			held_n = 1'b1;
		end else begin
			job.main = MAIN_LIT;
			col_n = sat_add(col_b, 2'd1);
		end
		if (msg_last) begin
			col_n = 8'd0;
		end

		// drop jobs that write nothing (a space being held)
		job_push = acc && ((job.held != HELD_NONE) || job.brk || (job.main != MAIN_NONE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_limit_q <= COL_RESET;
			col_q <= 8'd0;
			held_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				col_limit_q <= cfg_wdata;
			end
			if (acc) begin
				col_q <= col_n;
				held_q <= held_n;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/qpe_queue.sv
// Short job queue decoupling the classifier from the character sequencer.
`timescale 1ns / 1ps
`default_nettype none
module qpe_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input qpe_pkg::job_t push_job,
	output logic full,
	input wire logic pop,
	output qpe_pkg::job_t head,
	output logic head_valid
);
	import qpe_pkg::*;

	job_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0] cnt_q;

	assign full = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule
`default_nettype wire

### hdl/qpe_back.sv
// Back end: walks the head job's slots, one beat per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none
module qpe_back (
	input wire logic clk,
	input wire logic arst_n,
	input qpe_pkg::job_t head,
	input wire logic head_valid,
	output logic pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic [7:0] out_byte,
	output logic run_last,
	output logic msg_end
);
	import qpe_pkg::*;

	logic [NSLOT-1:0] done_q;
	logic [NSLOT-1:0] present, rem, pick;
	logic [7:0] chr [NSLOT];
	logic [7:0] sel;
	logic last_slot, issue;

	always_comb begin
		present[0] = (head.held != HELD_NONE);
		present[1] = (head.held == HELD_EQ20);
		present[2] = (head.held == HELD_EQ20);
		present[3] = head.brk;
		present[4] = head.brk;
		present[5] = head.brk;
		present[6] = (head.main != MAIN_NONE);
		present[7] = (head.main == MAIN_ESC);
		present[8] = (head.main == MAIN_ESC);

		chr[0] = (head.held == HELD_EQ20) ? CH_EQ : CH_SPACE;
		chr[1] = CH_TWO;
		chr[2] = CH_ZERO;
		chr[3] = CH_EQ;
		chr[4] = CH_CR;
		chr[5] = CH_LF;
		chr[6] = (head.main == MAIN_ESC) ? CH_EQ : head.data;
		chr[7] = hex_digit(head.data[7:4]);
		chr[8] = hex_digit(head.data[3:0]);

		// lowest slot still to go
		rem = present & ~done_q;
		pick = rem & (~rem + 1'b1);
		last_slot = ((rem & ~pick) == '0);
		sel = '0;
		for (int i = 0; i < NSLOT; i++) begin
			sel = sel | (pick[i] ? chr[i] : 8'd0);
		end

		issue = head_valid && (!out_valid || out_ready);
		pop = issue && last_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (issue) begin
				out_valid <= 1'b1;
				done_q <= last_slot ? '0 : (done_q | pick);
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			out_byte <= sel;
			run_last <= last_slot;
			msg_end <= last_slot && head.last;
		end
	end

endmodule
`default_nettype wire

### hdl/quoted_printable_encoder_unit.sv
// Top level of the streaming quoted-printable encoder.
// With the queue empty, a byte's job is first written into the job queue, then its first character is registered.
// Throughput: the output port moves one character per cycle while m_tready is high and a job is queued; a byte
//   expands into 0 to 7 characters (3 for an escape); the back end's single output register sets it.
// Input beats are taken every cycle while the 4-entry job queue has room.
// Reset (arst_n low, asynchronous): column 0, no space held, queue empty, column limit 73.
`timescale 1ns / 1ps
`default_nettype none
module quoted_printable_encoder_unit (
	input wire logic clk,
	input wire logic arst_n,
	// column limit register
	input wire logic cfg_wen,
	input wire logic [7:0] cfg_wdata,
	// message bytes in
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tdata, // [7:0] in_byte
	input wire logic s_tlast, // msg_last
	// encoded characters out
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [7:0] m_tdata, // [7:0] out_byte
	output logic m_tlast, // run_last
	output logic m_tuser // [0] msg_end
);
	import qpe_pkg::*;

	job_t fr_job, hd_job;
	logic fr_push, q_full, hd_valid, bk_pop, s_acc;

	// Take a beat whenever the queue can hold the job it may create.
	assign s_tready = !q_full;
	assign s_acc = s_tvalid && s_tready;

	// Front: column tracking, held-space handling and byte classification.
	qpe_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.acc(s_acc),
		.in_byte(s_tdata),
		.msg_last(s_tlast),
		.job(fr_job),
		.job_push(fr_push)
	);

	// Queue: lets input keep flowing while escapes and soft breaks drain.
	qpe_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(fr_push),
		.push_job(fr_job),
		.full(q_full),
		.pop(bk_pop),
		.head(hd_job),
		.head_valid(hd_valid)
	);

	// Back: expand each job into characters behind a registered output beat.
	qpe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(hd_job),
		.head_valid(hd_valid),
		.pop(bk_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_byte(m_tdata),
		.run_last(m_tlast),
		.msg_end(m_tuser)
	);

endmodule
`default_nettype wire

### hdl/qpe_checker.sv
// Port-level checker for the quoted-printable encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "quoted_printable_encoder_unit_defines.svh"
module qpe_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic m_tlast,
	input wire logic m_tuser
);
	import qpe_pkg::*;

	`QPE_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
	`QPE_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
	`QPE_ASSERT_NOW(a_end_is_last, m_tvalid && m_tuser, m_tlast)
	`QPE_ASSERT_NEXT(a_break_lf, m_tvalid && m_tready && m_tdata == CH_CR && !m_tlast, m_tvalid && m_tdata == CH_LF)

endmodule

bind quoted_printable_encoder_unit qpe_checker u_qpe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast),
	.m_tuser(m_tuser)
);
`default_nettype wire
